>>> src/strict_base64url_decoder_unit_macros.svh
// assertion helpers for the base64url decoder
`ifndef STRICT_BASE64URL_DECODER_UNIT_MACROS_SVH
`define STRICT_BASE64URL_DECODER_UNIT_MACROS_SVH

// checked on every rising edge outside reset
`define B64U_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// checked on every rising edge, reset included
`define B64U_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

>>> src/b64u_pkg.sv
package b64u_pkg;

    typedef struct packed {
        logic [7:0] char_code;
        logic       is_last;
    } t_in_item;

    typedef struct packed {
        logic       byte_valid;
        logic [7:0] data_byte;
        logic       text_done;
        logic [1:0] status;
    } t_out_item;

    // status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_LENGTH   = 2'd1;
    localparam logic [1:0] ST_BAD_CHAR = 2'd2;
    localparam logic [1:0] ST_TRAILING = 2'd3;

    // group positions
    localparam logic [1:0] POS_FIRST  = 2'd0;
    localparam logic [1:0] POS_SECOND = 2'd1;
    localparam logic [1:0] POS_THIRD  = 2'd2;

    localparam logic [5:0] SEXTET_LOWER_BASE = 6'd26;
    localparam logic [5:0] SEXTET_DIGIT_BASE = 6'd52;
    localparam logic [5:0] SEXTET_DASH       = 6'd62;
    localparam logic [5:0] SEXTET_UNDERSCORE = 6'd63;

    typedef struct packed {
        logic       bad;
        logic [5:0] value;
    } t_sextet;

    // alphabet lookup, bad flag set for anything outside it
    function automatic t_sextet sextet_of(input logic [7:0] c);
        t_sextet r;
        logic [7:0] d;
        r.bad   = 1'b0;
        r.value = '0;
        if (c >= 8'h41 && c <= 8'h5A) begin
            d       = c - 8'h41;
            r.value = d[5:0];
        end else if (c >= 8'h61 && c <= 8'h7A) begin
            d       = c - 8'h61;
            r.value = d[5:0] + SEXTET_LOWER_BASE;
        end else if (c >= 8'h30 && c <= 8'h39) begin
            d       = c - 8'h30;
            r.value = d[5:0] + SEXTET_DIGIT_BASE;
        end else if (c == 8'h2D) begin
            r.value = SEXTET_DASH;
        end else if (c == 8'h5F) begin
            r.value = SEXTET_UNDERSCORE;
        end else begin
            r.bad = 1'b1;
        end
        return r;
    endfunction

endpackage

>>> src/strict_base64url_decoder_unit.sv
// strict unpadded base64url decoder, one character per transaction
// input channel: i_in_valid / o_in_ready carry char_code and is_last;
//   is_last marks the final character of a text, texts follow back to back
// output channel: o_out_valid / i_out_ready carry exactly one result per
//   character: byte_valid/data_byte for the decoded byte (second, third and
//   fourth character of each group), text_done/status on the last character
// status: 0 ok, 1 length leaves one char, 2 bad character, 3 nonzero
//   trailing bits; on any nonzero status the text's bytes must be discarded
//   by the user, as the block does not enforce it; throughput: one character
//   per cycle unless the output stalls; the decode path is one alphabet
//   lookup and a byte merge between the input register and result register
// stall: while the result register is held, the input register still takes
//   one more character; o_in_ready drops only when both registers are full
// reset: synchronous active-low i_rst_n empties both registers and clears
//   the group position, held sextet and sticky bad-character flag
module strict_base64url_decoder_unit
    import b64u_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_data
);

`include "strict_base64url_decoder_unit_macros.svh"

    // input register
    logic      r_s1_valid;
    t_in_item  r_s1_item;
    // result register
    logic      r_out_valid;
    t_out_item r_out_item;
    // decode state
    logic [1:0] r_group_pos,   n_group_pos;
    logic [5:0] r_held_sextet, n_held_sextet;
    logic       r_bad_seen,    n_bad_seen;

    logic      adv;
    t_sextet   lookup;
    logic [5:0] sx;
    logic      bad_all;
    t_out_item n_out_item;

    // stage moves when the result register is free or being drained
    assign adv        = r_s1_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_s1_valid || adv;

    always_comb begin
        lookup  = sextet_of(r_s1_item.char_code);
        // bad characters decode as zero and poison the rest of the text
        sx      = lookup.bad ? 6'd0 : lookup.value;
        bad_all = r_bad_seen | lookup.bad;

        n_out_item            = '0;
        n_out_item.text_done  = r_s1_item.is_last;
        n_out_item.byte_valid = !bad_all && (r_group_pos != POS_FIRST);

        if (n_out_item.byte_valid) begin
            unique case (r_group_pos)
                POS_SECOND: n_out_item.data_byte = {r_held_sextet, sx[5:4]};
                POS_THIRD:  n_out_item.data_byte = {r_held_sextet[3:0], sx[5:2]};
                default:    n_out_item.data_byte = {r_held_sextet[1:0], sx};
            endcase
        end

        // status priority: length, then bad character, then trailing bits
        if (r_s1_item.is_last) begin
            priority if (r_group_pos == POS_FIRST) begin
                n_out_item.status = ST_LENGTH;
            end else if (bad_all) begin
                n_out_item.status = ST_BAD_CHAR;
            end else if (r_group_pos == POS_SECOND && sx[3:0] != 4'd0) begin
                n_out_item.status = ST_TRAILING;
            end else if (r_group_pos == POS_THIRD && sx[1:0] != 2'd0) begin
                n_out_item.status = ST_TRAILING;
            end else begin
                n_out_item.status = ST_OK;
            end
        end

        // end of text returns to the reset state
        if (r_s1_item.is_last) begin
            n_group_pos   = '0;
            n_held_sextet = '0;
            n_bad_seen    = 1'b0;
        end else begin
            n_group_pos   = r_group_pos + 2'd1;
            n_held_sextet = sx;
            n_bad_seen    = bad_all;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid    <= 1'b0;
            r_out_valid   <= 1'b0;
            r_group_pos   <= '0;
            r_held_sextet <= '0;
            r_bad_seen    <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_s1_valid <= i_in_valid;
            end
            if (adv) begin
                r_out_valid   <= 1'b1;
                r_group_pos   <= n_group_pos;
                r_held_sextet <= n_held_sextet;
                r_bad_seen    <= n_bad_seen;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_s1_item <= i_in_data;
        end
        if (adv) begin
            r_out_item <= n_out_item;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_item;

    // status only on the final result of a text
    `B64U_ASSERT(a_status_only_at_end, o_out_valid && !o_out_data.text_done |-> o_out_data.status == ST_OK, "status set before end of text")
    // a length error falls on a group start, which never carries a byte
    `B64U_ASSERT(a_length_no_byte, o_out_valid && o_out_data.status == ST_LENGTH |-> !o_out_data.byte_valid, "byte emitted with length error")
    // the last character always leaves the decode state cleared
    `B64U_ASSERT(a_state_cleared, adv && r_s1_item.is_last |=> r_group_pos == POS_FIRST && !r_bad_seen && r_held_sextet == 6'd0, "state not cleared after end of text")
    // reset empties the result register
    `B64U_ASSERT_ALWAYS(a_reset_empty, !i_rst_n |=> !o_out_valid && !r_s1_valid, "pipeline not empty after reset")

endmodule
